// File: rtl/fsri_pkg.sv
package fsri_pkg;

   localparam int SIDE   = 16;
   localparam int AREA   = SIDE * SIDE;
   localparam int IDX_W  = $clog2(SIDE);
   localparam int ADDR_W = $clog2(AREA);
   localparam int PIX_W  = 8;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIDE - 1);
   localparam logic [PIX_W-1:0] INV_BASE = PIX_W'(51);

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_READ   = 3'd1,
      OP_SCROLL = 3'd2,
      OP_ROTATE = 3'd3,
      OP_INVERT = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      addr_of = ADDR_W'(int'(r) * SIDE + int'(c));
   endfunction

endpackage

// File: rtl/frame_scroll_rotate_invert.sv
// Scroll, rotate and invert sweep the frame at one pixel per cycle, through the
// frame store read port into the other bank. One transaction at a time; the next
// is taken the cycle after the result is registered.
// Reset (synchronous): a clearing pass writes zero to all AREA = 256 pixels of bank 0,
// one per cycle, with req_tready low.
module frame_scroll_rotate_invert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] row, [7:4] col, [15:8] pixel, [17:16] row_shift, [19:18] col_shift,
   // [20] wrap, [28:21] fill, [29] rotate_dir, [31:30] zero
   input  logic [31:0] req_tdata,
   // [2:0] operation
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]  rsp_tdata
);

   localparam int IW = fsri_pkg::IDX_W;
   localparam int AW = fsri_pkg::ADDR_W;
   localparam int PW = fsri_pkg::PIX_W;

   logic [3:0]    req_row, req_col;
   logic [PW-1:0] req_pixel, req_fill;
   logic [1:0]    req_row_shift, req_col_shift;
   logic          req_wrap, req_rotate_dir;
   fsri_pkg::op_type req_op;
   logic          req_inside, accept;

   assign req_row        = req_tdata[3:0];
   assign req_col        = req_tdata[7:4];
   assign req_pixel      = req_tdata[15:8];
   assign req_row_shift  = req_tdata[17:16];
   assign req_col_shift  = req_tdata[19:18];
   assign req_wrap       = req_tdata[20];
   assign req_fill       = req_tdata[28:21];
   assign req_rotate_dir = req_tdata[29];
   assign req_op         = fsri_pkg::op_type'(req_tuser);
   assign req_inside     = (int'(req_row) < fsri_pkg::SIDE) && (int'(req_col) < fsri_pkg::SIDE);
   assign accept         = req_tvalid && req_tready;

   fsri_pkg::state_type state_ff, state_in;
   logic [IW-1:0] cnt_r_ff, cnt_r_in, cnt_c_ff, cnt_c_in;
   logic          bank_sel_ff, bank_sel_in;
   fsri_pkg::op_type op_ff;
   logic [1:0]    rs_ff, cs_ff;
   logic          wrap_ff, ccw_ff, inside_ff;
   logic [PW-1:0] fill_ff;
   logic          pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0] pipe_addr_ff;
   logic          pipe_fill_ff;
   logic [PW-1:0] rd_data_ff;
   logic [PW-1:0] result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_data_ff;

   logic [PW-1:0] bank0_mem [fsri_pkg::AREA];
   logic [PW-1:0] bank1_mem [fsri_pkg::AREA];

   logic          cnt_last, cnt_step, rsp_load, cmd_load;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en, wr_bank;
   logic [PW-1:0] wr_data;

   // source pixel for the current destination of a frame sweep
   logic [IW-1:0] src_r, src_c;
   logic          src_fill;

   assign cnt_last = (cnt_r_ff == fsri_pkg::IDX_LAST) && (cnt_c_ff == fsri_pkg::IDX_LAST);

   always_comb begin
      logic [IW-1:0] sc;
      logic          cfill, rfill;
      sc       = cnt_c_ff;
      cfill    = 1'b0;
      rfill    = 1'b0;
      src_r    = cnt_r_ff;
      src_c    = cnt_c_ff;
      src_fill = 1'b0;
      unique case (op_ff)
         fsri_pkg::OP_SCROLL: begin
            // column move is last, so resolve it first
            if (cs_ff == 2'b01) begin
               if (cnt_c_ff == fsri_pkg::IDX_LAST) begin
                  sc    = '0;
                  cfill = !wrap_ff;
               end else begin
                  sc = cnt_c_ff + 1'b1;
               end
            end else if (cs_ff[1]) begin
               if (cnt_c_ff == '0) begin
                  sc    = fsri_pkg::IDX_LAST;
                  cfill = !wrap_ff;
               end else begin
                  sc = cnt_c_ff - 1'b1;
               end
            end
            if (rs_ff == 2'b01) begin
               if (cnt_r_ff == fsri_pkg::IDX_LAST) begin
                  src_r = '0;
                  rfill = !wrap_ff;
               end else begin
                  src_r = cnt_r_ff + 1'b1;
               end
            end else if (rs_ff[1]) begin
               if (cnt_r_ff == '0) begin
                  src_r = fsri_pkg::IDX_LAST;
                  rfill = !wrap_ff;
               end else begin
                  src_r = cnt_r_ff - 1'b1;
               end
            end
            src_c    = sc;
            src_fill = cfill || rfill;
         end
         fsri_pkg::OP_ROTATE: begin
            if (ccw_ff) begin
               src_r = cnt_c_ff;
               src_c = fsri_pkg::IDX_LAST - cnt_r_ff;
            end else begin
               src_r = fsri_pkg::IDX_LAST - cnt_c_ff;
               src_c = cnt_r_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsri_pkg::ST_CLEAR: if (cnt_last) state_in = fsri_pkg::ST_IDLE;
         fsri_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  fsri_pkg::OP_READ:   state_in = fsri_pkg::ST_READ;
                  fsri_pkg::OP_SCROLL,
                  fsri_pkg::OP_ROTATE,
                  fsri_pkg::OP_INVERT: state_in = fsri_pkg::ST_SWEEP;
                  default:             state_in = fsri_pkg::ST_DONE;
               endcase
            end
         end
         fsri_pkg::ST_READ:  state_in = fsri_pkg::ST_DONE;
         fsri_pkg::ST_SWEEP: if (cnt_last) state_in = fsri_pkg::ST_DRAIN;
         fsri_pkg::ST_DRAIN: state_in = fsri_pkg::ST_DONE;
         fsri_pkg::ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = fsri_pkg::ST_IDLE;
         default:            state_in = fsri_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cnt_step      = 1'b0;
      cmd_load      = 1'b0;
      rsp_load      = 1'b0;
      pipe_valid_in = 1'b0;
      bank_sel_in   = bank_sel_ff;
      result_in     = result_ff;
      rd_addr       = fsri_pkg::addr_of(src_r, src_c);
      wr_en         = 1'b0;
      wr_bank       = bank_sel_ff;
      wr_addr       = fsri_pkg::addr_of(cnt_r_ff, cnt_c_ff);
      wr_data       = '0;
      unique case (state_ff)
         fsri_pkg::ST_CLEAR: begin
            wr_en    = 1'b1;
            cnt_step = 1'b1;
         end
         fsri_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd_load   = accept;
            result_in  = '0;
            rd_addr    = fsri_pkg::addr_of(IW'(req_row), IW'(req_col));
            wr_addr    = rd_addr;
            wr_data    = req_pixel;
            wr_en      = accept && (req_op == fsri_pkg::OP_WRITE) && req_inside;
         end
         fsri_pkg::ST_READ: begin
            result_in = inside_ff ? rd_data_ff : '0;
         end
         fsri_pkg::ST_SWEEP: begin
            pipe_valid_in = 1'b1;
            cnt_step      = 1'b1;
         end
         fsri_pkg::ST_DRAIN: begin
            bank_sel_in = !bank_sel_ff;
         end
         fsri_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
      if (pipe_valid_ff) begin
         wr_en   = 1'b1;
         wr_bank = !bank_sel_ff;
         wr_addr = pipe_addr_ff;
         if (pipe_fill_ff) begin
            wr_data = fill_ff;
         end else if (op_ff == fsri_pkg::OP_INVERT) begin
            wr_data = fsri_pkg::INV_BASE - rd_data_ff;
         end else begin
            wr_data = rd_data_ff;
         end
      end
   end

   always_comb begin
      cnt_r_in = cnt_r_ff;
      cnt_c_in = cnt_c_ff;
      if (cnt_step) begin
         if (cnt_c_ff == fsri_pkg::IDX_LAST) begin
            cnt_c_in = '0;
            cnt_r_in = (cnt_r_ff == fsri_pkg::IDX_LAST) ? '0 : cnt_r_ff + 1'b1;
         end else begin
            cnt_c_in = cnt_c_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsri_pkg::ST_CLEAR;
         cnt_r_ff      <= '0;
         cnt_c_ff      <= '0;
         bank_sel_ff   <= 1'b0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_r_ff      <= cnt_r_in;
         cnt_c_ff      <= cnt_c_in;
         bank_sel_ff   <= bank_sel_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_load) begin
         op_ff     <= req_op;
         rs_ff     <= req_row_shift;
         cs_ff     <= req_col_shift;
         wrap_ff   <= req_wrap;
         fill_ff   <= req_fill;
         ccw_ff    <= req_rotate_dir;
         inside_ff <= req_inside;
      end
      pipe_addr_ff <= fsri_pkg::addr_of(cnt_r_ff, cnt_c_ff);
      pipe_fill_ff <= src_fill;
      result_ff    <= result_in;
      if (rsp_load) begin
         rsp_data_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         bank0_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) begin
         bank1_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bank_sel_ff ? bank1_mem[rd_addr] : bank0_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
